// File: src/dbpa_pkg.sv
// Shared types and constants for the single-bin DFT phasor accumulator.
`default_nettype none

package dbpa_pkg;

    // Field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int ROT_W      = 16;
    localparam int PH_W       = 32;
    localparam int ACC_W      = 40;
    localparam int OUT_W      = 28;
    localparam int PROD_W     = 48;
    localparam int SQ_W       = 56;
    localparam int REM_W      = 30;
    localparam int CFG_IDX_W  = 8;
    localparam int ROOT_CNT_W = 5;

    // Fixed-point scaling
    localparam int MAC_SHIFT = 30;
    localparam int ROT_SHIFT = 15;

    // Square root runs one result bit per step
    localparam logic [ROOT_CNT_W-1:0] ROOT_LAST_STEP = ROOT_CNT_W'(OUT_W - 1);

    // Reset values
    localparam logic signed [PH_W-1:0]  PH_ONE        = PH_W'(32'sd1073741824);
    localparam logic signed [ROT_W-1:0] ROT_COS_RST   = 16'sd32767;
    localparam logic signed [ROT_W-1:0] ROT_NSIN_RST  = 16'sd0;

    // Saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [PH_W-1:0]  PH_MAX  = {1'b0, {(PH_W-1){1'b1}}};
    localparam logic signed [PH_W-1:0]  PH_MIN  = {1'b1, {(PH_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_NEG_SIN = CFG_IDX_W'(1);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SAT,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_EMIT
    } dbpa_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul;
        logic acc;
        logic sat;
        logic square;
        logic root_init;
        logic root_step;
        logic emit;
    } dbpa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic frame_end;
    } dbpa_stat_t;

endpackage

`default_nettype wire

// File: src/dbpa_if.sv
// Stream interfaces for samples, results and configuration writes.
`default_nettype none

interface dbpa_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface dbpa_result_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] real_part;
    logic signed [27:0] imag_part;
    logic        [27:0] magnitude;

    modport source (output valid, output real_part, output imag_part, output magnitude,
                    input ready);
    modport sink (input valid, input real_part, input imag_part, input magnitude,
                  output ready);
endinterface

interface dbpa_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/dbpa_ctrl.sv
// Sequencing state machine for the phasor accumulator.
`default_nettype none

module dbpa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    input  wire dbpa_pkg::dbpa_stat_t stat,
    output dbpa_pkg::dbpa_cmd_t       cmd
);
    import dbpa_pkg::*;

    dbpa_state_t            state_reg;
    dbpa_state_t            state_next;
    logic [ROOT_CNT_W-1:0]  cnt_reg;
    logic [ROOT_CNT_W-1:0]  cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_free;

    // Output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_ACC;
            ST_ACC:       state_next = stat.frame_end ? ST_SAT : ST_IDLE;
            ST_SAT:       state_next = ST_SQUARE;
            ST_SQUARE:    state_next = ST_ROOT_INIT;
            ST_ROOT_INIT: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:      cmd.load_in   = in_valid;
            ST_MUL:       cmd.mul       = 1'b1;
            ST_ACC:       cmd.acc       = 1'b1;
            ST_SAT:       cmd.sat       = 1'b1;
            ST_SQUARE:    cmd.square    = 1'b1;
            ST_ROOT_INIT: cmd.root_init = 1'b1;
            ST_ROOT:      cmd.root_step = 1'b1;
            ST_EMIT:      cmd.emit      = out_free;
            default:      cmd = '0;
        endcase
    end

    // Step counter for the square root
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == ST_ROOT_INIT)
        begin
            cnt_next = ROOT_LAST_STEP;
        end
        else if (state_reg == ST_ROOT && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - ROOT_CNT_W'(1);
        end
    end

    // Hold a result until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: src/dbpa_datapath.sv
// Multipliers, accumulators, phasor rotation and square root of the squared magnitude.
`default_nettype none

module dbpa_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire dbpa_pkg::dbpa_cmd_t                    cmd,
    input  wire logic signed [dbpa_pkg::SAMPLE_W-1:0]   sample,
    input  wire logic                                   last,
    input  wire logic                                   cfg_we,
    input  wire logic        [dbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic signed [dbpa_pkg::ROT_W-1:0]      cfg_data,
    output dbpa_pkg::dbpa_stat_t                        stat,
    output logic signed      [dbpa_pkg::OUT_W-1:0]      real_part,
    output logic signed      [dbpa_pkg::OUT_W-1:0]      imag_part,
    output logic             [dbpa_pkg::OUT_W-1:0]      magnitude
);
    import dbpa_pkg::*;

    localparam logic signed [PROD_W-1:0]  MAC_HALF = PROD_W'(1) <<< (MAC_SHIFT - 1);
    localparam logic signed [PROD_W:0]    ROT_HALF = (PROD_W + 1)'(1) <<< (ROT_SHIFT - 1);

    // Configuration and frame state
    logic signed [ROT_W-1:0]    rot_cos_reg;
    logic signed [ROT_W-1:0]    rot_nsin_reg;
    logic signed [ACC_W-1:0]    acc_r_reg;
    logic signed [ACC_W-1:0]    acc_i_reg;
    logic signed [ACC_W-1:0]    acc_r_next;
    logic signed [ACC_W-1:0]    acc_i_next;
    logic signed [PH_W-1:0]     ph_r_reg;
    logic signed [PH_W-1:0]     ph_i_reg;
    logic signed [PH_W-1:0]     ph_r_next;
    logic signed [PH_W-1:0]     ph_i_next;

    // Pipeline payload
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic signed [PROD_W-1:0]   mxr_reg;
    logic signed [PROD_W-1:0]   mxi_reg;
    logic signed [PROD_W-1:0]   mrc_reg;
    logic signed [PROD_W-1:0]   mis_reg;
    logic signed [PROD_W-1:0]   mrs_reg;
    logic signed [PROD_W-1:0]   mic_reg;
    logic signed [OUT_W-1:0]    re_sat_reg;
    logic signed [OUT_W-1:0]    im_sat_reg;
    logic signed [OUT_W-1:0]    re_sat_next;
    logic signed [OUT_W-1:0]    im_sat_next;
    logic signed [SQ_W-1:0]     sq_r_reg;
    logic signed [SQ_W-1:0]     sq_i_reg;
    logic        [SQ_W-1:0]     n_reg;
    logic        [REM_W-1:0]    rem_reg;
    logic        [REM_W-1:0]    rem_next;
    logic        [OUT_W-1:0]    root_reg;
    logic signed [OUT_W-1:0]    real_out_reg;
    logic signed [OUT_W-1:0]    imag_out_reg;
    logic        [OUT_W-1:0]    mag_out_reg;

    // Combinational intermediates
    logic signed [PROD_W-1:0]   mac_r;
    logic signed [PROD_W-1:0]   mac_i;
    logic signed [ACC_W:0]      sum_r;
    logic signed [ACC_W:0]      sum_i;
    logic signed [PROD_W:0]     rot_r;
    logic signed [PROD_W:0]     rot_i;
    logic        [REM_W+1:0]    rem_sh;
    logic        [REM_W+1:0]    trial;
    logic        [REM_W+1:0]    diff;
    logic                       take;

    // Round the sample products and add with saturation
    assign mac_r = (mxr_reg + MAC_HALF) >>> MAC_SHIFT;
    assign mac_i = (mxi_reg + MAC_HALF) >>> MAC_SHIFT;
    assign sum_r = $signed({acc_r_reg[ACC_W-1], acc_r_reg}) + $signed(mac_r[ACC_W:0]);
    assign sum_i = $signed({acc_i_reg[ACC_W-1], acc_i_reg}) + $signed(mac_i[ACC_W:0]);

    always_comb
    begin
        if (sum_r[ACC_W] != sum_r[ACC_W-1])
        begin
            acc_r_next = sum_r[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_r_next = sum_r[ACC_W-1:0];
        end
        if (sum_i[ACC_W] != sum_i[ACC_W-1])
        begin
            acc_i_next = sum_i[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_i_next = sum_i[ACC_W-1:0];
        end
    end

    // Combine and round the rotation products, saturate to the phasor width
    assign rot_r = ($signed({mrc_reg[PROD_W-1], mrc_reg}) - $signed({mis_reg[PROD_W-1], mis_reg})
                    + ROT_HALF) >>> ROT_SHIFT;
    assign rot_i = ($signed({mrs_reg[PROD_W-1], mrs_reg}) + $signed({mic_reg[PROD_W-1], mic_reg})
                    + ROT_HALF) >>> ROT_SHIFT;

    always_comb
    begin
        if (rot_r[PROD_W:PH_W-1] == '0 || rot_r[PROD_W:PH_W-1] == '1)
        begin
            ph_r_next = rot_r[PH_W-1:0];
        end
        else
        begin
            ph_r_next = rot_r[PROD_W] ? PH_MIN : PH_MAX;
        end
        if (rot_i[PROD_W:PH_W-1] == '0 || rot_i[PROD_W:PH_W-1] == '1)
        begin
            ph_i_next = rot_i[PH_W-1:0];
        end
        else
        begin
            ph_i_next = rot_i[PROD_W] ? PH_MIN : PH_MAX;
        end
    end

    // Clamp the accumulators to the output width
    always_comb
    begin
        if (acc_r_reg[ACC_W-1:OUT_W-1] == '0 || acc_r_reg[ACC_W-1:OUT_W-1] == '1)
        begin
            re_sat_next = acc_r_reg[OUT_W-1:0];
        end
        else
        begin
            re_sat_next = acc_r_reg[ACC_W-1] ? OUT_MIN : OUT_MAX;
        end
        if (acc_i_reg[ACC_W-1:OUT_W-1] == '0 || acc_i_reg[ACC_W-1:OUT_W-1] == '1)
        begin
            im_sat_next = acc_i_reg[OUT_W-1:0];
        end
        else
        begin
            im_sat_next = acc_i_reg[ACC_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    // One square root digit: bring down two bits, try to subtract
    assign rem_sh   = {rem_reg, n_reg[SQ_W-1:SQ_W-2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign take     = (rem_sh >= trial);
    assign diff     = rem_sh - trial;
    assign rem_next = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];

    // Configuration and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_cos_reg  <= ROT_COS_RST;
            rot_nsin_reg <= ROT_NSIN_RST;
            acc_r_reg    <= '0;
            acc_i_reg    <= '0;
            ph_r_reg     <= PH_ONE;
            ph_i_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_ROT_COS)
            begin
                rot_cos_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_ROT_NEG_SIN)
            begin
                rot_nsin_reg <= cfg_data;
            end
            if (cmd.acc)
            begin
                acc_r_reg <= acc_r_next;
                acc_i_reg <= acc_i_next;
                ph_r_reg  <= ph_r_next;
                ph_i_reg  <= ph_i_next;
            end
            else if (cmd.sat)
            begin
                // Frame done: return to the start of a new frame
                acc_r_reg <= '0;
                acc_i_reg <= '0;
                ph_r_reg  <= PH_ONE;
                ph_i_reg  <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg    <= sample;
            last_reg <= last;
        end
        if (cmd.mul)
        begin
            mxr_reg <= x_reg * ph_r_reg;
            mxi_reg <= x_reg * ph_i_reg;
            mrc_reg <= ph_r_reg * rot_cos_reg;
            mis_reg <= ph_i_reg * rot_nsin_reg;
            mrs_reg <= ph_r_reg * rot_nsin_reg;
            mic_reg <= ph_i_reg * rot_cos_reg;
        end
        if (cmd.sat)
        begin
            re_sat_reg <= re_sat_next;
            im_sat_reg <= im_sat_next;
        end
        if (cmd.square)
        begin
            sq_r_reg <= re_sat_reg * re_sat_reg;
            sq_i_reg <= im_sat_reg * im_sat_reg;
        end
        if (cmd.root_init)
        begin
            n_reg    <= sq_r_reg + sq_i_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            n_reg    <= {n_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[OUT_W-2:0], take};
        end
        if (cmd.emit)
        begin
            real_out_reg <= re_sat_reg;
            imag_out_reg <= im_sat_reg;
            mag_out_reg  <= root_reg;
        end
    end

    assign stat.frame_end = last_reg;
    assign real_part      = real_out_reg;
    assign imag_part      = imag_out_reg;
    assign magnitude      = mag_out_reg;

endmodule

`default_nettype wire

// File: src/dtft_bin_phasor_accumulator_unit.sv
// Top level: single-bin DFT by phasor rotation with saturating complex accumulator.
// Samples are not overlapped: each is accepted, multiplied and accumulated/rotated
// before the next is taken. A sample marked last then runs saturate, square, root
// init, the 28-step bit-serial square root and emit (which waits for a free result slot).
// Reset: rot_cos = 32767, rot_neg_sin = 0, phasor = 1+0j, accumulators zero,
// no result pending. Configuration writes are taken in every cycle.
`default_nettype none

module dtft_bin_phasor_accumulator_unit (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dbpa_sample_if.sink    sample_stream,
    dbpa_result_if.source  result_stream,
    dbpa_cfg_if.sink       cfg
);
    import dbpa_pkg::*;

    dbpa_cmd_t  cmd;
    dbpa_stat_t stat;
    logic       cfg_we;

    // Register writes are always accepted
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    dbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_stream.valid),
        .in_ready  (sample_stream.ready),
        .out_ready (result_stream.ready),
        .out_valid (result_stream.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    dbpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample_stream.sample),
        .last      (sample_stream.last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .stat      (stat),
        .real_part (result_stream.real_part),
        .imag_part (result_stream.imag_part),
        .magnitude (result_stream.magnitude)
    );

endmodule

`default_nettype wire
